// ===== rtl/core/ilid_pkg.sv =====
// Shared types, constants and codes for the indexed list block.
package ilid_pkg;

	localparam int CAPACITY = 64;
	localparam int DATA_W = 32;
	localparam int POS_W = 7;
	localparam int LEN_W = 7;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam logic [2:0] OP_READ = 3'd0;
	localparam logic [2:0] OP_INSERT_AT = 3'd1;
	localparam logic [2:0] OP_INSERT_HEAD = 3'd2;
	localparam logic [2:0] OP_INSERT_TAIL = 3'd3;
	localparam logic [2:0] OP_DELETE = 3'd4;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_BAD_POS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [2:0] operation;
		logic [POS_W-1:0] position;
		logic signed [DATA_W-1:0] value;
	} req_word_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_value;
		logic [1:0] status;
		logic [LEN_W-1:0] list_length;
	} rsp_word_t;

	typedef enum logic [1:0] {
		CMD_HOLD = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_DELETE = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic [CMP_W-1:0] pos;
		logic [DATA_W-1:0] value;
		logic [CMP_W-1:0] rd_pos;
	} slot_cmd_t;

endpackage

// ===== rtl/core/indexed_list_insert_delete_top.sv =====
// Top level of the indexed list: request decode, length counter, slot row, result register.
//
//  channel | direction | handshake            | word
//  req     | in        | req_valid/req_stall  | operation, position, value
//  rsp     | out       | rsp_valid/rsp_stall  | read_value, status, list_length
//
// Each request is decoded and applied to the whole row of slots at once.
// Its result appears in the output register on the following cycle.
// A new request is taken in every cycle unless a result is held by a stall.
// Reset clears the length and the output valid; slot contents stay undefined.
module indexed_list_insert_delete_top import ilid_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input req_word_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output rsp_word_t rsp
);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] next_cnt;
	logic rsp_valid_q;
	rsp_word_t rsp_q;
	logic accept;
	logic full;
	logic [CMP_W-1:0] pos_ext;
	logic [CMP_W-1:0] cnt_ext;
	cmd_kind_t kind;
	logic [CMP_W-1:0] ins_pos;
	logic [1:0] status;
	logic [DATA_W-1:0] rd_val;
	logic [DATA_W-1:0] read_bus;
	slot_cmd_t cmd;
	logic [DATA_W-1:0] slot_data [CAPACITY];
	logic [DATA_W-1:0] slot_rd [CAPACITY];

	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	assign pos_ext = CMP_W'(req.position);
	assign cnt_ext = CMP_W'(count_q);
	assign full = (cnt_ext == CMP_W'(CAPACITY));

	always_comb begin
		read_bus = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			read_bus = read_bus | slot_rd[i];
		end
	end

	always_comb begin
		kind = CMD_HOLD;
		ins_pos = pos_ext;
		status = ST_DONE;
		rd_val = '1;
		next_cnt = count_q;
		case (req.operation)
			OP_READ: begin
				if (pos_ext < cnt_ext) begin
					rd_val = read_bus;
				end else begin
					status = ST_BAD_POS;
				end
			end
			OP_INSERT_AT: begin
				if (pos_ext > cnt_ext) begin
					status = ST_BAD_POS;
				end else if (full) begin
					status = ST_FULL;
				end else begin
					kind = CMD_INSERT;
				end
			end
			OP_INSERT_HEAD: begin
				ins_pos = '0;
				if (full) begin
					status = ST_FULL;
				end else begin
					kind = CMD_INSERT;
				end
			end
			OP_INSERT_TAIL: begin
				ins_pos = cnt_ext;
				if (full) begin
					status = ST_FULL;
				end else begin
					kind = CMD_INSERT;
				end
			end
			OP_DELETE: begin
				if (pos_ext < cnt_ext) begin
					kind = CMD_DELETE;
					next_cnt = count_q - CNT_W'(1);
				end else begin
					status = ST_BAD_POS;
				end
			end
			default: begin
				status = ST_BAD_POS;
			end
		endcase
		if (kind == CMD_INSERT) begin
			next_cnt = count_q + CNT_W'(1);
		end
	end

	always_comb begin
		cmd.kind = accept ? kind : CMD_HOLD;
		cmd.pos = ins_pos;
		cmd.value = req.value;
		cmd.rd_pos = pos_ext;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
		logic [DATA_W-1:0] left_d;
		logic [DATA_W-1:0] right_d;
		if (i == 0) begin : g_first
			assign left_d = req.value;
		end else begin : g_left
			assign left_d = slot_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_d = slot_data[i];
		end else begin : g_right
			assign right_d = slot_data[i+1];
		end
		ilid_cell u_slot (
			.clk(clk),
			.idx(IDX_W'(i)),
			.cmd(cmd),
			.left_data(left_d),
			.right_data(right_d),
			.data(slot_data[i]),
			.rd_data(slot_rd[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= next_cnt;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.read_value <= rd_val;
			rsp_q.status <= status;
			rsp_q.list_length <= LEN_W'(next_cnt);
		end
	end

endmodule

// ===== rtl/core/ilid_cell.sv =====
// One list slot: holds an entry and shifts it to or from its neighbours.
module ilid_cell import ilid_pkg::*; (
	input logic clk,
	input logic [IDX_W-1:0] idx,
	input slot_cmd_t cmd,
	input logic [DATA_W-1:0] left_data,
	input logic [DATA_W-1:0] right_data,
	output logic [DATA_W-1:0] data,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] data_q;
	logic [CMP_W-1:0] idx_ext;

	assign idx_ext = CMP_W'(idx);
	assign data = data_q;
	assign rd_data = (idx_ext == cmd.rd_pos) ? data_q : '0;

	always_ff @(posedge clk) begin
		case (cmd.kind)
			CMD_INSERT: begin
				if (idx_ext > cmd.pos) begin
					data_q <= left_data;
				end else if (idx_ext == cmd.pos) begin
					data_q <= cmd.value;
				end
			end
			CMD_DELETE: begin
				if (idx_ext >= cmd.pos) begin
					data_q <= right_data;
				end
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

endmodule

// ===== verif/indexed_list_insert_delete_top_test.sv =====
// Self-checking testbench for the indexed list block, with random idling on both channels.
`timescale 1ns / 100ps

module indexed_list_insert_delete_top_test;
	import ilid_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 500;
	localparam int PRINT_LIMIT = 100;
	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	typedef enum int {
		BURST_FILL,
		BURST_DRAIN,
		BURST_CHURN
	} burst_kind_t;

	logic clk;
	logic arst_n;
	logic req_valid = 1'b0;
	logic req_stall;
	req_word_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_word_t rsp;

	req_word_t pending_reqs[$];
	rsp_word_t awaited_rsps[$];
	logic [DATA_W-1:0] list_mem [CAPACITY];
	int list_len = 0;
	int gen_len = 0;
	int n_queued = 0;
	int n_taken = 0;
	int mismatch_count = 0;
	int quiet_cycles = 0;
	logic req_fire = 1'b0;
	logic running = 1'b0;
	logic calm;

	assign calm = (n_taken >= 200) && (n_taken < 350);

	indexed_list_insert_delete_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic note_mismatch(input string msg);
		if (mismatch_count < PRINT_LIMIT) begin
			$display("MISMATCH at %0t: %s", $time, msg);
		end
		mismatch_count++;
	endtask

	function automatic logic [1:0] list_put(input int p, input logic [DATA_W-1:0] v);
		int i;
		if (list_len >= CAPACITY) begin
			return ST_FULL;
		end
		for (i = list_len; i > p; i--) begin
			list_mem[i] = list_mem[i-1];
		end
		list_mem[p] = v;
		list_len++;
		return ST_DONE;
	endfunction

	task automatic apply_request(input req_word_t r);
		rsp_word_t e;
		int p;
		int i;
		e.read_value = -1;
		e.status = ST_DONE;
		p = int'(r.position);
		case (r.operation)
			OP_READ: begin
				if (p < list_len) begin
					e.read_value = list_mem[p];
				end else begin
					e.status = ST_BAD_POS;
				end
			end
			OP_INSERT_AT: begin
				if (p > list_len) begin
					e.status = ST_BAD_POS;
				end else begin
					e.status = list_put(p, r.value);
				end
			end
			OP_INSERT_HEAD: e.status = list_put(0, r.value);
			OP_INSERT_TAIL: e.status = list_put(list_len, r.value);
			OP_DELETE: begin
				if (p < list_len) begin
					for (i = p; i + 1 < list_len; i++) begin
						list_mem[i] = list_mem[i+1];
					end
					list_len--;
				end else begin
					e.status = ST_BAD_POS;
				end
			end
			default: e.status = ST_BAD_POS;
		endcase
		e.list_length = LEN_W'(list_len);
		awaited_rsps = {awaited_rsps, e};
	endtask

	task automatic check_rsp(input rsp_word_t got);
		rsp_word_t want;
		if (awaited_rsps.size() == 0) begin
			note_mismatch($sformatf("result word %h arrived with none expected", got));
			return;
		end
		want = awaited_rsps.pop_front();
		if (got.read_value !== want.read_value) begin
			note_mismatch($sformatf("read_value %0d, expected %0d",
				got.read_value, want.read_value));
		end
		if (got.status !== want.status) begin
			note_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
		end
		if (got.list_length !== want.list_length) begin
			note_mismatch($sformatf("list_length %0d, expected %0d",
				got.list_length, want.list_length));
		end
	endtask

	task automatic queue_item(input logic [2:0] op, input int pos, input logic [DATA_W-1:0] val);
		req_word_t w;
		w.operation = op;
		w.position = pos[POS_W-1:0];
		w.value = val;
		pending_reqs = {pending_reqs, w};
		n_queued++;
		case (op)
			OP_INSERT_AT: begin
				if (pos <= gen_len && gen_len < CAPACITY) begin
					gen_len++;
				end
			end
			OP_INSERT_HEAD, OP_INSERT_TAIL: begin
				if (gen_len < CAPACITY) begin
					gen_len++;
				end
			end
			OP_DELETE: begin
				if (pos < gen_len) begin
					gen_len--;
				end
			end
			default: ;
		endcase
	endtask

	function automatic int pick_pos();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return $urandom_range(0, gen_len);
		end else if (r < 85) begin
			return gen_len + $urandom_range(0, 1);
		end
		return $urandom_range(0, (1 << POS_W) - 1);
	endfunction

	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 19))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [2:0] pick_op(input burst_kind_t kind);
		int r;
		int ins;
		int del;
		case (kind)
			BURST_FILL: begin
				ins = 80;
				del = 5;
			end
			BURST_DRAIN: begin
				ins = 10;
				del = 70;
			end
			default: begin
				ins = 30;
				del = 30;
			end
		endcase
		r = $urandom_range(0, 99);
		if (r < ins) begin
			return 3'($urandom_range(OP_INSERT_AT, OP_INSERT_TAIL));
		end else if (r < ins + del) begin
			return OP_DELETE;
		end else if (r < 95) begin
			return OP_READ;
		end
		return 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
	endfunction

	always @(negedge clk) begin
		if (running) begin
			if (!(req_valid && !req_fire)) begin
				if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= 33)) begin
					req <= pending_reqs.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
			rsp_stall <= !calm && ($urandom_range(0, 99) < 33);
		end
	end

	always @(posedge clk) begin
		running <= arst_n;
		req_fire <= arst_n && req_valid && !req_stall;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				apply_request(req);
				n_taken <= n_taken + 1;
			end
			if (rsp_valid && !rsp_stall) begin
				check_rsp(rsp);
			end
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
				$display("indexed_list_insert_delete_top verification failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		burst_kind_t kind;
		int burst;
		int k;
		int n_random;
		logic [2:0] op;
		arst_n = 1'b0;

		// Empty list: reads, deletes, an insert past the tail are out of range; then a list is built.
		queue_item(OP_READ, 0, '0);
		queue_item(OP_READ, 127, '0);
		queue_item(OP_DELETE, 0, '0);
		queue_item(OP_INSERT_AT, 1, 32'h0000_0005);
		queue_item(OP_INSERT_AT, 0, 32'h8000_0000);
		queue_item(OP_INSERT_HEAD, 0, 32'h7fff_ffff);
		queue_item(OP_INSERT_TAIL, 127, '0);
		queue_item(OP_INSERT_AT, 3, '1);
		queue_item(OP_INSERT_AT, 2, 32'h1234_5678);
		queue_item(OP_INSERT_AT, 127, 32'hdead_beef);
		for (k = 0; k < 6; k++) begin
			queue_item(OP_READ, k, '0);
		end
		queue_item(OP_DELETE, 2, '0);
		queue_item(OP_DELETE, 4, '0);
		queue_item(OP_DELETE, 3, '0);
		for (k = OP_SPARE_LO; k <= OP_SPARE_HI; k++) begin
			queue_item(k[2:0], 0, 32'h5555_aaaa);
		end
		queue_item(OP_READ, 0, '0);
		queue_item(OP_DELETE, 0, '0);
		queue_item(OP_READ, 1, '0);

		// The opening burst fills the list so that full refusals come early.
		kind = BURST_FILL;
		burst = 110;
		n_random = 0;
		while (n_random < RANDOM_ITEMS) begin
			for (k = 0; k < burst && n_random < RANDOM_ITEMS; k++) begin
				op = pick_op(kind);
				queue_item(op, pick_pos(), pick_value());
				n_random++;
			end
			kind = burst_kind_t'($urandom_range(BURST_FILL, BURST_CHURN));
			burst = $urandom_range(20, 80);
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (n_taken < n_queued || awaited_rsps.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("indexed_list_insert_delete_top verification clean");
		end else begin
			$display("indexed_list_insert_delete_top verification failed");
		end
		$finish;
	end

endmodule
